[hw/rtl/lcsp_pkg.sv]
// ----------------------------------------------------------------------------
// lcsp_pkg
// Shared constants for the LED command stream parser: field widths, event
// codes, command numbers and the table of five-character command names.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsp_pkg;

    localparam int MAX_LEDS = 256;

    localparam int BYTE_W   = 8;
    localparam int EVENT_W  = 3;
    localparam int CMD_W    = 5;
    localparam int COUNT_W  = 9;
    localparam int NAME_W   = 40;

    // Event codes carried on the result channel.
    localparam logic [EVENT_W-1:0] EV_CMD_DECODED = 3'd0;
    localparam logic [EVENT_W-1:0] EV_LED_WRITE   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_FRAME_OK    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FRAME_BAD   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_VENDOR_DONE = 3'd4;
    localparam logic [EVENT_W-1:0] EV_RESET_SER   = 3'd5;

    // Command numbers with special handling.
    localparam logic [CMD_W-1:0] CMD_RNUMB   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_SLEDS   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_VENDO   = 5'd17;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 5'd19;

    localparam int CMD_TOTAL = 19;

    // Configuration register indexes.
    localparam logic CFG_LED_COUNT     = 1'b0;
    localparam logic CFG_RIGHT_TO_LEFT = 1'b1;

    // Header and terminator bytes.
    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'hFF;
    localparam int                HDR_LEN    = 6;
    localparam int                CMD_CHARS  = 5;
    localparam logic [BYTE_W-1:0] TAIL_BYTE0 = 8'hFF;
    localparam logic [BYTE_W-1:0] TAIL_BYTE1 = 8'hFE;
    localparam logic [BYTE_W-1:0] TAIL_BYTE2 = 8'hFD;

    typedef logic [NAME_W-1:0] t_name_tab [CMD_TOTAL];

    // Command names in command number order, first character in the top byte.
    localparam t_name_tab CMD_NAMES = '{
        "proto", "dname", "bname", "dpict", "ddete", "dtype", "ulock",
        "snumb", "rnumb", "ledsc", "ledsl", "butdc", "sleds", "matxc",
        "smatx", "fansc", "sfans", "vendo", "unloc"
    };

endpackage

`default_nettype wire

[hw/rtl/led_command_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// led_command_stream_parser_core
// Output: a result appears on the output register in the cycle after the byte
// that completes it is accepted.
// Throughput: one byte per cycle unless a held result stalls input; each byte
// is parsed when accepted; input stays open while the single output drains.
// Reset: synchronous active-low reset returns to header hunting, empties the
// output register and restores led_count to 21 and right_to_left to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module led_command_stream_parser_core #(
    parameter int MAX_LEDS = lcsp_pkg::MAX_LEDS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Byte input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [lcsp_pkg::BYTE_W-1:0]    i_rx_byte,
    // Result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [lcsp_pkg::EVENT_W-1:0]   o_event_res,
    output logic      [lcsp_pkg::CMD_W-1:0]     o_command_id,
    output logic      [lcsp_pkg::BYTE_W-1:0]    o_led_slot,
    output logic      [lcsp_pkg::BYTE_W-1:0]    o_red,
    output logic      [lcsp_pkg::BYTE_W-1:0]    o_green,
    output logic      [lcsp_pkg::BYTE_W-1:0]    o_blue,
    // Configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [lcsp_pkg::COUNT_W-1:0]   i_cfg_data
);

    localparam logic [lcsp_pkg::COUNT_W-1:0] MAX_N = lcsp_pkg::COUNT_W'(MAX_LEDS);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LED,
        PH_TAIL,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP
    } t_phase;

    // Configuration
    logic [lcsp_pkg::COUNT_W-1:0] r_led_count;
    logic                         r_right_to_left;

    // Parser state
    t_phase                       r_phase, n_phase;
    logic [2:0]                   r_ff_run, n_ff_run;
    logic [31:0]                  r_chars, n_chars;
    logic [2:0]                   r_char_count, n_char_count;
    logic [lcsp_pkg::COUNT_W-1:0] r_led_pos, n_led_pos;
    logic [1:0]                   r_color, n_color;
    logic [7:0]                   r_red_hold, n_red_hold;
    logic [7:0]                   r_green_hold, n_green_hold;
    logic [1:0]                   r_tail_count, n_tail_count;
    logic                         r_tail_good, n_tail_good;
    logic [15:0]                  r_skip, n_skip;
    logic [7:0]                   r_len_high, n_len_high;

    // Output register
    logic                         r_out_valid;
    logic [lcsp_pkg::EVENT_W-1:0] r_event, n_event;
    logic [lcsp_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [7:0]                   r_slot, n_slot;
    logic [7:0]                   r_red, n_red;
    logic [7:0]                   r_green, n_green;
    logic [7:0]                   r_blue, n_blue;
    logic                         n_emit;

    logic                         in_xfer;
    logic [lcsp_pkg::CMD_W-1:0]   cmd_id;
    logic [lcsp_pkg::COUNT_W-1:0] frame_n;
    logic [lcsp_pkg::COUNT_W-1:0] pos_next;
    logic [lcsp_pkg::COUNT_W-1:0] slot_rev;
    logic [7:0]                   tail_expect;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    lcsp_cmd_decode u_decode (
        .i_chars  ({r_chars, i_rx_byte}),
        .o_cmd_id (cmd_id)
    );

    always_comb begin
        if (r_led_count == '0) begin
            frame_n = lcsp_pkg::COUNT_W'(1);
        end else if (r_led_count > MAX_N) begin
            frame_n = MAX_N;
        end else begin
            frame_n = r_led_count;
        end
    end

    assign pos_next = r_led_pos + lcsp_pkg::COUNT_W'(1);
    assign slot_rev = frame_n - pos_next;

    always_comb begin
        case (r_tail_count)
            2'd0:    tail_expect = lcsp_pkg::TAIL_BYTE0;
            2'd1:    tail_expect = lcsp_pkg::TAIL_BYTE1;
            default: tail_expect = lcsp_pkg::TAIL_BYTE2;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_ff_run     = r_ff_run;
        n_chars      = r_chars;
        n_char_count = r_char_count;
        n_led_pos    = r_led_pos;
        n_color      = r_color;
        n_red_hold   = r_red_hold;
        n_green_hold = r_green_hold;
        n_tail_count = r_tail_count;
        n_tail_good  = r_tail_good;
        n_skip       = r_skip;
        n_len_high   = r_len_high;
        n_emit       = 1'b0;
        n_event      = lcsp_pkg::EV_CMD_DECODED;
        n_cmd        = lcsp_pkg::CMD_SLEDS;
        n_slot       = '0;
        n_red        = '0;
        n_green      = '0;
        n_blue       = '0;

        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == lcsp_pkg::HDR_BYTE) begin
                    if (r_ff_run == 3'(lcsp_pkg::HDR_LEN - 1)) begin
                        n_phase      = PH_CMD;
                        n_ff_run     = '0;
                        n_char_count = '0;
                    end else begin
                        n_ff_run = r_ff_run + 3'd1;
                    end
                end else begin
                    n_ff_run = '0;
                end
            end
            PH_CMD: begin
                n_chars      = {r_chars[23:0], i_rx_byte};
                n_char_count = r_char_count + 3'd1;
                if (r_char_count == 3'(lcsp_pkg::CMD_CHARS - 1)) begin
                    n_emit       = 1'b1;
                    n_cmd        = cmd_id;
                    n_event      = (cmd_id == lcsp_pkg::CMD_RNUMB) ?
                                   lcsp_pkg::EV_RESET_SER : lcsp_pkg::EV_CMD_DECODED;
                    n_char_count = '0;
                    n_ff_run     = '0;
                    if (cmd_id == lcsp_pkg::CMD_SLEDS) begin
                        n_phase   = PH_LED;
                        n_led_pos = '0;
                        n_color   = '0;
                    end else if (cmd_id == lcsp_pkg::CMD_VENDO) begin
                        n_phase = PH_LEN_HI;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_LED: begin
                if (r_color == 2'd0) begin
                    n_red_hold = i_rx_byte;
                    n_color    = 2'd1;
                end else if (r_color == 2'd1) begin
                    n_green_hold = i_rx_byte;
                    n_color      = 2'd2;
                end else begin
                    n_emit    = 1'b1;
                    n_event   = lcsp_pkg::EV_LED_WRITE;
                    n_slot    = r_right_to_left ? slot_rev[7:0] : r_led_pos[7:0];
                    n_red     = r_red_hold;
                    n_green   = r_green_hold;
                    n_blue    = i_rx_byte;
                    n_color   = 2'd0;
                    n_led_pos = pos_next;
                    if (pos_next >= frame_n) begin
                        n_phase      = PH_TAIL;
                        n_tail_count = '0;
                        n_tail_good  = 1'b1;
                    end
                end
            end
            PH_TAIL: begin
                if (r_tail_count == 2'd2) begin
                    n_emit       = 1'b1;
                    n_event      = (r_tail_good && i_rx_byte == tail_expect) ?
                                   lcsp_pkg::EV_FRAME_OK : lcsp_pkg::EV_FRAME_BAD;
                    n_tail_count = '0;
                    n_tail_good  = 1'b1;
                    n_phase      = PH_HUNT;
                    n_ff_run     = '0;
                    n_char_count = '0;
                end else begin
                    n_tail_count = r_tail_count + 2'd1;
                    n_tail_good  = r_tail_good && (i_rx_byte == tail_expect);
                end
            end
            PH_LEN_HI: begin
                n_len_high = i_rx_byte;
                n_phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_skip = {r_len_high, i_rx_byte};
                if ({r_len_high, i_rx_byte} == 16'd0) begin
                    n_emit       = 1'b1;
                    n_event      = lcsp_pkg::EV_VENDOR_DONE;
                    n_cmd        = lcsp_pkg::CMD_VENDO;
                    n_phase      = PH_HUNT;
                    n_ff_run     = '0;
                    n_char_count = '0;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                // The count is never zero here, so the last payload byte is
                // the one that finds it at one.
                n_skip = r_skip - 16'd1;
                if (r_skip <= 16'd1) begin
                    n_skip       = '0;
                    n_emit       = 1'b1;
                    n_event      = lcsp_pkg::EV_VENDOR_DONE;
                    n_cmd        = lcsp_pkg::CMD_VENDO;
                    n_phase      = PH_HUNT;
                    n_ff_run     = '0;
                    n_char_count = '0;
                end
            end
            default: begin
                n_phase      = PH_HUNT;
                n_ff_run     = '0;
                n_char_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count     <= lcsp_pkg::COUNT_W'(21);
            r_right_to_left <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcsp_pkg::CFG_LED_COUNT:     r_led_count     <= i_cfg_data;
                lcsp_pkg::CFG_RIGHT_TO_LEFT: r_right_to_left <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_ff_run     <= '0;
            r_chars      <= '0;
            r_char_count <= '0;
            r_led_pos    <= '0;
            r_color      <= '0;
            r_red_hold   <= '0;
            r_green_hold <= '0;
            r_tail_count <= '0;
            r_tail_good  <= 1'b1;
            r_skip       <= '0;
            r_len_high   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_phase      <= n_phase;
                r_ff_run     <= n_ff_run;
                r_chars      <= n_chars;
                r_char_count <= n_char_count;
                r_led_pos    <= n_led_pos;
                r_color      <= n_color;
                r_red_hold   <= n_red_hold;
                r_green_hold <= n_green_hold;
                r_tail_count <= n_tail_count;
                r_tail_good  <= n_tail_good;
                r_skip       <= n_skip;
                r_len_high   <= n_len_high;
            end
            if (in_xfer && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_event <= n_event;
            r_cmd   <= n_cmd;
            r_slot  <= n_slot;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_res  = r_event;
    assign o_command_id = r_cmd;
    assign o_led_slot   = r_slot;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;

`ifndef NO_ASSERTIONS
    // A byte taken while hunting for the header never produces a result.
    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && r_phase == PH_HUNT |=> !r_out_valid)
        else $error("result produced by a header hunt byte");

    // Every LED write belongs to the LED frame command.
    a_led_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_event == lcsp_pkg::EV_LED_WRITE |->
        r_cmd == lcsp_pkg::CMD_SLEDS)
        else $error("LED write with wrong command");

    // The color phase never reaches its unused code.
    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_color != 2'd3)
        else $error("color phase out of range");

    // The terminator counter stays within three bytes.
    a_tail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_count != 2'd3)
        else $error("terminator count out of range");
`endif

endmodule

`default_nettype wire

[hw/rtl/lcsp_cmd_decode.sv]
// ----------------------------------------------------------------------------
// lcsp_cmd_decode
// Matches five collected command characters against the command name table
// and returns the command number, or the unknown code when nothing matches.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsp_cmd_decode (
    input  wire logic [lcsp_pkg::NAME_W-1:0] i_chars,
    output logic      [lcsp_pkg::CMD_W-1:0]  o_cmd_id
);

    // Names are distinct, so at most one entry matches; scanning downward
    // lets the lowest number win anyway.
    always_comb begin
        o_cmd_id = lcsp_pkg::CMD_UNKNOWN;
        for (int k = lcsp_pkg::CMD_TOTAL - 1; k >= 0; k--) begin
            if (i_chars == lcsp_pkg::CMD_NAMES[k]) begin
                o_cmd_id = lcsp_pkg::CMD_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

[dv/led_command_stream_parser_core_test.sv]
// ----------------------------------------------------------------------------
// led_command_stream_parser_core_test
// Self-checking testbench for the LED command stream parser. A queue of bytes
// feeds a valid/ready driver, and every accepted byte goes through a local
// model of the parser that queues the events it should produce. A monitor
// compares each result transfer with the oldest queued event, field by field.
// The run walks through several register settings and idling patterns,
// including a long receiver hold-off and a sender pause until fully drained.
// ----------------------------------------------------------------------------
`default_nettype none

module led_command_stream_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcsp_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PRINT_LIMIT     = 100;

    typedef enum logic [2:0] {
        P_HUNT, P_COMMAND, P_LED, P_TRAILER, P_LEN_HI, P_LEN_LO, P_SKIP
    } parse_state_t;

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [CMD_W-1:0]   cmd;
        logic [7:0]         slot;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } led_event_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [EVENT_W-1:0]   o_event_res;
    logic [CMD_W-1:0]     o_command_id;
    logic [BYTE_W-1:0]    o_led_slot;
    logic [BYTE_W-1:0]    o_red;
    logic [BYTE_W-1:0]    o_green;
    logic [BYTE_W-1:0]    o_blue;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [COUNT_W-1:0]   i_cfg_data;

    led_command_stream_parser_core dut (.*);

    // Bytes waiting to be offered and events waiting to be seen.
    logic [7:0]  tx_bytes[$];
    led_event_t  expected_events[$];

    int          planned_bytes = 0;
    int          failures = 0;
    int          results_seen = 0;
    int          stall_cycles = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    bit          byte_sent = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_served = 1'b0;
    int          hold_left = 0;

    // Register copies and parser state of the local model.
    logic [COUNT_W-1:0] led_count_cfg = 9'd21;
    logic               reverse_cfg = 1'b0;
    parse_state_t       parse_state = P_HUNT;
    int                 ff_count = 0;
    logic [NAME_W-1:0]  cmd_word = '0;
    int                 cmd_len = 0;
    int                 leds_done = 0;
    int                 color_step = 0;
    logic [7:0]         red_hold = '0;
    logic [7:0]         green_hold = '0;
    int                 trailer_count = 0;
    bit                 trailer_ok = 1'b1;
    logic [15:0]        skip_count = '0;
    logic [7:0]         len_hi = '0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [NAME_W-1:0] command_name(input int idx);
        case (idx)
            0:  return "proto";
            1:  return "dname";
            2:  return "bname";
            3:  return "dpict";
            4:  return "ddete";
            5:  return "dtype";
            6:  return "ulock";
            7:  return "snumb";
            8:  return "rnumb";
            9:  return "ledsc";
            10: return "ledsl";
            11: return "butdc";
            12: return "sleds";
            13: return "matxc";
            14: return "smatx";
            15: return "fansc";
            16: return "sfans";
            17: return "vendo";
            18: return "unloc";
            default: return "zzzzz";
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] lookup_command(input logic [NAME_W-1:0] word);
        for (int i = 0; i < CMD_TOTAL; i++) begin
            if (command_name(i) == word) return CMD_W'(i);
        end
        return CMD_UNKNOWN;
    endfunction

    // Register values outside 1..MAX_LEDS are clamped into range.
    function automatic int leds_per_frame();
        if (led_count_cfg == '0) return 1;
        if (led_count_cfg > COUNT_W'(MAX_LEDS)) return MAX_LEDS;
        return int'(led_count_cfg);
    endfunction

    task automatic expect_event(input logic [EVENT_W-1:0] ev, input logic [CMD_W-1:0] cmd,
                                input logic [7:0] slot, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b);
        expected_events.push_back('{ev: ev, cmd: cmd, slot: slot, red: r, green: g, blue: b});
    endtask

    task automatic restart_hunt();
        parse_state = P_HUNT;
        ff_count    = 0;
        cmd_word    = '0;
        cmd_len     = 0;
    endtask

    task automatic predict_byte(input logic [7:0] rx);
        logic [CMD_W-1:0] id;
        logic [7:0]       slot;
        logic [7:0]       trailer_byte;
        int               n;
        case (parse_state)
            P_HUNT: begin
                if (rx == HDR_BYTE) begin
                    ff_count++;
                    if (ff_count >= HDR_LEN) begin
                        restart_hunt();
                        parse_state = P_COMMAND;
                    end
                end else begin
                    ff_count = 0;
                end
            end
            P_COMMAND: begin
                cmd_word = {cmd_word[NAME_W-9:0], rx};
                cmd_len++;
                if (cmd_len >= CMD_CHARS) begin
                    id = lookup_command(cmd_word);
                    restart_hunt();
                    if (id == CMD_SLEDS) begin
                        parse_state = P_LED;
                        leds_done   = 0;
                        color_step  = 0;
                    end else if (id == CMD_VENDO) begin
                        parse_state = P_LEN_HI;
                    end
                    expect_event((id == CMD_RNUMB) ? EV_RESET_SER : EV_CMD_DECODED,
                                 id, '0, '0, '0, '0);
                end
            end
            P_LED: begin
                if (color_step == 0) begin
                    red_hold   = rx;
                    color_step = 1;
                end else if (color_step == 1) begin
                    green_hold = rx;
                    color_step = 2;
                end else begin
                    n    = leds_per_frame();
                    slot = reverse_cfg ? 8'(n - 1 - leds_done) : 8'(leds_done);
                    color_step = 0;
                    leds_done++;
                    if (leds_done >= n) begin
                        parse_state   = P_TRAILER;
                        trailer_count = 0;
                        trailer_ok    = 1'b1;
                    end
                    expect_event(EV_LED_WRITE, CMD_SLEDS, slot, red_hold, green_hold, rx);
                end
            end
            P_TRAILER: begin
                case (trailer_count)
                    0:       trailer_byte = TAIL_BYTE0;
                    1:       trailer_byte = TAIL_BYTE1;
                    default: trailer_byte = TAIL_BYTE2;
                endcase
                if (rx != trailer_byte) trailer_ok = 1'b0;
                trailer_count++;
                if (trailer_count >= 3) begin
                    expect_event(trailer_ok ? EV_FRAME_OK : EV_FRAME_BAD, CMD_SLEDS,
                                 '0, '0, '0, '0);
                    trailer_count = 0;
                    trailer_ok    = 1'b1;
                    restart_hunt();
                end
            end
            P_LEN_HI: begin
                len_hi      = rx;
                parse_state = P_LEN_LO;
            end
            P_LEN_LO: begin
                skip_count = {len_hi, rx};
                if (skip_count == '0) begin
                    restart_hunt();
                    expect_event(EV_VENDOR_DONE, CMD_VENDO, '0, '0, '0, '0);
                end else begin
                    parse_state = P_SKIP;
                end
            end
            default: begin
                if (skip_count != '0) skip_count--;
                if (skip_count == '0) begin
                    restart_hunt();
                    expect_event(EV_VENDOR_DONE, CMD_VENDO, '0, '0, '0, '0);
                end
            end
        endcase
    endtask

    task automatic report_failure(input string what);
        failures++;
        if (failures <= PRINT_LIMIT)
            $display("[%0t] result %0d: %s", $realtime, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got != want)
            report_failure($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Byte driver: a new byte is chosen only after the previous transfer.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || byte_sent)) begin
            byte_sent = 1'b0;
            if (tx_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_rx_byte  <= tx_bytes.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_byte(i_rx_byte);
            byte_sent = 1'b1;
        end
    end

    // Result receiver, with one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_request && !hold_served) begin
            hold_left   = HOLD_OFF_CYCLES;
            hold_served = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        led_event_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_events.size() == 0) begin
                report_failure($sformatf("unexpected event %0d, command %0d",
                                         o_event_res, o_command_id));
            end else begin
                want = expected_events.pop_front();
                check_field("event_res", 32'(o_event_res), 32'(want.ev));
                check_field("command_id", 32'(o_command_id), 32'(want.cmd));
                check_field("led_slot", 32'(o_led_slot), 32'(want.slot));
                check_field("red", 32'(o_red), 32'(want.red));
                check_field("green", 32'(o_green), 32'(want.green));
                check_field("blue", 32'(o_blue), 32'(want.blue));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        planned_bytes++;
    endtask

    task automatic push_header();
        repeat (HDR_LEN) push_byte(HDR_BYTE);
    endtask

    task automatic push_command(input int idx);
        logic [NAME_W-1:0] name;
        name = command_name(idx);
        for (int k = CMD_CHARS - 1; k >= 0; k--) push_byte(name[k*8 +: 8]);
    endtask

    task automatic push_led_frame(input bit good_tail);
        logic [7:0] tail [3];
        logic [7:0] b;
        int         bad_pos;
        tail[0] = TAIL_BYTE0;
        tail[1] = TAIL_BYTE1;
        tail[2] = TAIL_BYTE2;
        push_header();
        push_command(int'(CMD_SLEDS));
        repeat (3 * leds_per_frame()) push_byte(8'($urandom_range(255)));
        bad_pos = good_tail ? 3 : int'($urandom_range(2));
        for (int k = 0; k < 3; k++) begin
            b = tail[k];
            if (k == bad_pos || (!good_tail && $urandom_range(3) == 0)) begin
                b = 8'($urandom_range(255));
                if (b == tail[k]) b = b ^ (8'h01 << $urandom_range(7));
            end
            push_byte(b);
        end
    endtask

    task automatic push_vendor(input logic [15:0] length);
        push_header();
        push_command(int'(CMD_VENDO));
        push_byte(length[15:8]);
        push_byte(length[7:0]);
        for (int k = 0; k < int'(length); k++) push_byte(8'($urandom_range(255)));
    endtask

    // Mostly well-formed frames with random content; the rest is broken
    // headers, surplus header bytes, cut-off commands and line noise.
    task automatic push_random_sequence();
        int pick;
        pick = int'($urandom_range(99));
        if (pick < 30) begin
            push_led_frame($urandom_range(9) != 0);
        end else if (pick < 42) begin
            if ($urandom_range(9) == 0)
                push_vendor(16'($urandom_range(600, 200)));
            else
                push_vendor(16'($urandom_range(24)));
        end else if (pick < 70) begin
            push_header();
            push_command(int'($urandom_range(CMD_TOTAL - 1)));
        end else if (pick < 76) begin
            push_header();
            repeat (CMD_CHARS) push_byte(8'($urandom_range(255)));
        end else if (pick < 82) begin
            // Header bytes beyond the sixth are taken as command characters.
            push_header();
            repeat ($urandom_range(3, 1)) push_byte(HDR_BYTE);
            push_command(int'($urandom_range(CMD_TOTAL - 1)));
        end else if (pick < 90) begin
            repeat ($urandom_range(5, 1)) push_byte(HDR_BYTE);
            push_byte(8'($urandom_range(254)));
            push_command(int'($urandom_range(CMD_TOTAL - 1)));
        end else if (pick < 95) begin
            push_header();
            repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(8, 1)) tx_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic fill_random(input int target);
        while (planned_bytes < target) push_random_sequence();
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LED_COUNT)
            led_count_cfg = value;
        else
            reverse_cfg = value[0];
    endtask

    // Registers change only with nothing in flight and the parser hunting.
    task automatic set_up_phase(input logic [COUNT_W-1:0] count, input logic reverse,
                                input int unsigned sender_pct,
                                input int unsigned receiver_pct);
        wait_drained();
        while (parse_state != P_HUNT) begin
            tx_bytes.push_back(8'h00);
            wait_drained();
        end
        write_register(CFG_LED_COUNT, count);
        write_register(CFG_RIGHT_TO_LEFT, {{(COUNT_W-1){1'b0}}, reverse});
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_LED_COUNT;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: broken header run, a full frame, the reset
        // serial command, empty and short vendor payloads, an unknown name.
        repeat (3) push_byte(HDR_BYTE);
        push_byte(8'h00);
        push_led_frame(1'b1);
        push_header();
        push_command(int'(CMD_RNUMB));
        push_vendor(16'd0);
        push_vendor(16'd3);
        push_header();
        push_command(CMD_TOTAL);
        fill_random(220);

        set_up_phase(9'd1, 1'b1, 80, 0);
        push_led_frame(1'b0);
        push_led_frame(1'b1);
        fill_random(400);

        set_up_phase(9'd0, 1'b0, 0, 80);
        fill_random(580);

        set_up_phase(9'd5, 1'b1, 29, 29);
        fill_random(760);

        // A count above the maximum is clamped, so this frame is full length.
        set_up_phase(9'd511, 1'b1, 0, 0);
        push_led_frame(1'b1);
        push_header();
        push_command(int'(CMD_RNUMB));

        set_up_phase(9'($urandom_range(12, 2)), 1'($urandom_range(1)), 0, 0);
        fill_random(planned_bytes + 100);
        hold_request = 1'b1;

        set_up_phase(9'd3, 1'b0, 29, 29);
        fill_random(planned_bytes + 50);
        wait_drained();
        fill_random(planned_bytes + 50);

        wait_drained();
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[led_command_stream_parser_core.f]
hw/rtl/lcsp_pkg.sv
hw/rtl/lcsp_cmd_decode.sv
hw/rtl/led_command_stream_parser_core.sv
dv/led_command_stream_parser_core_test.sv
